### src/sspe_pkg.sv
// sspe_pkg: shared widths, action and status codes, and beat types
// for the stack positional edit engine; no dependencies
`timescale 1ns / 1ps

package sspe_pkg;

  // default number of stack entries
  localparam int DEPTH_DEF = 32;

  // field widths
  localparam int ACT_W  = 3;
  localparam int VAL_W  = 18;
  localparam int POS_W  = 6;
  localparam int ELEM_W = 19;
  localparam int ST_W   = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SWAP   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DOUBLE = 3'd5;
  localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd6;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd4;

  // control of the shared value unit
  typedef struct packed {
    logic use_key;  // output the key instead of the stored entry
    logic dbl;      // double the value
  } alu_ctl_t;

  // one result beat
  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic                     has_value;
    logic signed [ELEM_W-1:0] elem_value;
    logic                     found;
    logic [POS_W-1:0]         depth_count;
    logic                     last;
  } res_t;

endpackage

### src/sspe_store.sv
// sspe_store: stack entry memory, one write and one registered read port
// depends on sspe_pkg for the value width
`timescale 1ns / 1ps

module sspe_store
  import sspe_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/sspe_alu.sv
// sspe_alu: shared compare and value unit, key match and emitted value
// depends on sspe_pkg for widths and alu_ctl_t
`timescale 1ns / 1ps

module sspe_alu
  import sspe_pkg::*;
(
  input  logic signed [VAL_W-1:0]  entry,
  input  logic signed [VAL_W-1:0]  key,
  input  alu_ctl_t                 ctl,
  output logic                     match,
  output logic signed [ELEM_W-1:0] value
);

  logic signed [VAL_W-1:0] src;

  // key compare against the entry just read
  assign match = (entry == key);

  // pick source, then pass sign-extended or doubled
  assign src   = ctl.use_key ? key : entry;
  assign value = ctl.dbl ? {src, 1'b0} : {src[VAL_W-1], src};

endmodule

### src/sspe_ctrl.sv
// sspe_ctrl: sequencer for scans and runs, fill count and result register
// depends on sspe_pkg; drives sspe_store and sspe_alu
`timescale 1ns / 1ps

module sspe_ctrl
  import sspe_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  // input beats
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [VAL_W-1:0]  in_key,
  input  logic [POS_W-1:0]         in_pa,
  input  logic [POS_W-1:0]         in_pb,
  // result beats
  output logic                     out_valid,
  input  logic                     out_ready,
  output res_t                     res,
  // memory
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic signed [VAL_W-1:0]  mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  // shared unit
  output alu_ctl_t                 alu_ctl,
  output logic signed [VAL_W-1:0]  alu_key,
  input  logic                     alu_match,
  input  logic signed [ELEM_W-1:0] alu_val
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]              state, state_next;
  logic [FW-1:0]           fill, fill_next;
  logic [ACT_W-1:0]        op;
  logic signed [VAL_W-1:0] key;
  logic [POS_W-1:0]        pa, pb;
  logic [POS_W-1:0]        ord, ord_next;
  logic [POS_W-1:0]        dpos, dpos_next;
  res_t                    res_next;

  logic                    accept;
  logic [ACT_W-1:0]        op_c;
  logic [POS_W-1:0]        pa_c, pb_c;
  logic [POS_W-1:0]        fill6;
  logic                    full, empty;
  logic [POS_W-1:0]        run_len;
  logic [POS_W-1:0]        src_ord;
  logic [POS_W-1:0]        diff;

  function automatic res_t single(input logic [ST_W-1:0] st, input logic fnd,
                                  input logic [POS_W-1:0] dc);
    res_t r;
    r.status      = st;
    r.has_value   = 1'b0;
    r.elem_value  = '0;
    r.found       = fnd;
    r.depth_count = dc;
    r.last        = 1'b1;
    return r;
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign fill6     = POS_W'(fill);
  assign full      = (fill == FW'(DEPTH));
  assign empty     = (fill == '0);

  // current item fields, taken straight from the port in the accept cycle
  assign op_c = accept ? in_action : op;
  assign pa_c = accept ? in_pa : pa;
  assign pb_c = accept ? in_pb : pb;

  // number of beats in the run for the latched action
  always_comb begin
    case (op)
      ACT_INSERT: run_len = fill6 + POS_W'(1);
      ACT_DELETE: run_len = fill6 - POS_W'(1);
      default:    run_len = fill6;
    endcase
  end

  // shared unit control
  assign alu_key     = key;
  assign alu_ctl.use_key = (op == ACT_INSERT) && (ord == pa);
  assign alu_ctl.dbl     = (op == ACT_DOUBLE);

  // source ordinal of the next beat, then its memory address
  always_comb begin
    src_ord = ord_next;
    if (state_next != S_SCAN) begin
      case (op_c)
        ACT_INSERT: if (ord_next > pa_c) src_ord = ord_next - POS_W'(1);
        ACT_DELETE: if (ord_next >= dpos_next) src_ord = ord_next + POS_W'(1);
        ACT_SWAP: begin
          if (ord_next == pa_c) begin
            src_ord = pb_c;
          end else if (ord_next == pb_c) begin
            src_ord = pa_c;
          end
        end
        default: src_ord = ord_next;
      endcase
    end
  end

  assign diff      = fill6 - src_ord;
  assign mem_raddr = (diff < POS_W'(DEPTH)) ? diff[AW-1:0] : '0;
  assign mem_waddr = fill[AW-1:0];
  assign mem_wdata = in_key;

  // sequencer
  always_comb begin
    state_next = state;
    fill_next  = fill;
    ord_next   = ord;
    dpos_next  = dpos;
    res_next   = res;
    mem_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_OUT;
          ord_next   = POS_W'(1);
          case (in_action)
            ACT_PUSH: begin
              if (full) begin
                res_next = single(ST_FULL, 1'b0, fill6);
              end else begin
                mem_we    = 1'b1;
                fill_next = fill + FW'(1);
                res_next  = single(ST_OK, 1'b0, fill6 + POS_W'(1));
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                res_next = single(ST_OK, 1'b0, fill6);
              end else begin
                state_next = S_SCAN;
              end
            end
            ACT_INSERT: begin
              if (full) begin
                res_next = single(ST_FULL, 1'b0, fill6);
              end else if (in_pa == '0 || in_pa > fill6) begin
                res_next = single(ST_BADPOS, 1'b0, fill6);
              end else begin
                state_next = S_LD;
              end
            end
            ACT_DELETE: begin
              if (empty) begin
                res_next = single(ST_EMPTY, 1'b0, fill6);
              end else begin
                state_next = S_SCAN;
              end
            end
            ACT_SWAP: begin
              if (empty) begin
                res_next = single(ST_EMPTY, 1'b0, fill6);
              end else if (in_pa == '0 || in_pa > in_pb || in_pb > fill6) begin
                res_next = single(ST_BADPOS, 1'b0, fill6);
              end else begin
                state_next = S_LD;
              end
            end
            ACT_DOUBLE: begin
              if (empty) begin
                res_next = single(ST_EMPTY, 1'b0, fill6);
              end else begin
                state_next = S_LD;
              end
            end
            default: res_next = single(ST_OK, 1'b0, fill6);
          endcase
        end
      end
      S_SCAN: begin
        // entry at ordinal ord is on the read port
        if (alu_match) begin
          if (op == ACT_SEARCH) begin
            res_next   = single(ST_OK, 1'b1, fill6);
            state_next = S_OUT;
          end else if (fill6 == POS_W'(1)) begin
            // deleting the only element leaves an empty run
            res_next   = single(ST_OK, 1'b0, fill6);
            state_next = S_OUT;
          end else begin
            dpos_next  = ord;
            ord_next   = POS_W'(1);
            state_next = S_LD;
          end
        end else if (ord == fill6) begin
          res_next   = single((op == ACT_SEARCH) ? ST_OK : ST_NOTFOUND, 1'b0, fill6);
          state_next = S_OUT;
        end else begin
          ord_next = ord + POS_W'(1);
        end
      end
      S_LD: begin
        res_next.status      = ST_OK;
        res_next.has_value   = 1'b1;
        res_next.elem_value  = alu_val;
        res_next.found       = 1'b0;
        res_next.depth_count = fill6;
        res_next.last        = (ord == run_len);
        state_next           = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (res.last) begin
            state_next = S_IDLE;
          end else begin
            ord_next   = ord + POS_W'(1);
            state_next = S_LD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ord  <= ord_next;
    dpos <= dpos_next;
    res  <= res_next;
    if (accept) begin
      op  <= in_action;
      key <= in_key;
      pa  <= in_pa;
      pb  <= in_pb;
    end
  end

endmodule

### src/stack_positional_edit_engine.sv
// stack_positional_edit_engine: top level, stream ports and beat packing
// depends on sspe_pkg, sspe_store, sspe_alu and sspe_ctrl
`timescale 1ns / 1ps

// Bounded stack of signed 18-bit values, top at ordinal 1.
// One beat on s_axis carries an action; the block answers on m_axis with
// one beat, or for a successful insert, delete, swap or double with a run of beats that
// lists the edited copy of the stack from top to bottom, tlast on the end.
// The store itself only changes on push.
// Order of work per action:
//   push, count, errors: result valid in the cycle after the input beat
//   search: one entry read per cycle from the top until a match or the bottom
//   swap, double, insert: each run beat is set by the registered
//   memory read followed by the result register load
//   delete: a scan for the key as for search, then run beats as above
// s_axis_tready is high only while no item is in work; it rises the cycle
// after the last beat of a result is taken. A stalled m_axis holds its beat
// and the sequencer waits. Reset empties the stack at once (fill count 0)
// and leaves the block ready; stored entries are not cleared.
module stack_positional_edit_engine
  import sspe_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key_value[17:0], pos_a[23:18], pos_b[29:24]
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status[2:0], elem_value[21:3], found[22],
                                      // depth_count[28:23]
  output logic [0:0]  m_axis_tuser,   // has_value[0]
  output logic        m_axis_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic signed [VAL_W-1:0]  mem_wdata, mem_rdata;
  alu_ctl_t                 alu_ctl;
  logic signed [VAL_W-1:0]  alu_key;
  logic                     alu_match;
  logic signed [ELEM_W-1:0] alu_val;
  res_t                     res;

  sspe_ctrl #(.DEPTH(DEPTH), .AW(AW), .FW(FW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_key    (s_axis_tdata[17:0]),
    .in_pa     (s_axis_tdata[23:18]),
    .in_pb     (s_axis_tdata[29:24]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .alu_ctl   (alu_ctl),
    .alu_key   (alu_key),
    .alu_match (alu_match),
    .alu_val   (alu_val)
  );

  sspe_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sspe_alu u_alu (
    .entry (mem_rdata),
    .key   (alu_key),
    .ctl   (alu_ctl),
    .match (alu_match),
    .value (alu_val)
  );

  // result beat packing
  assign m_axis_tdata = {3'b000, res.depth_count, res.found, res.elem_value, res.status};
  assign m_axis_tuser = res.has_value;
  assign m_axis_tlast = res.last;

endmodule

### src/sspe_checker.sv
// sspe_checker: port-level assertions for the stack positional edit engine
// bound to stack_positional_edit_engine; no package dependencies
`timescale 1ns / 1ps

module sspe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // one item at a time: never ready for input while a result is shown
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // run beats always carry ok status
  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[2:0] == 3'd0)
    else $error("element beat with error status");

  // a beat without an element is a single result, so it is the last
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("single result without tlast");

  // taking the last beat frees the block for the next item
  a_free: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready after last beat");

endmodule

bind stack_positional_edit_engine sspe_checker u_sspe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
